// ===== hdl/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types, character codes and digit decode for the integer literal
// parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned AddrW  = 4;

  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharMinus      = 8'h2D;
  localparam logic [7:0] CharPlus       = 8'h2B;
  localparam logic [7:0] CharLowerX     = 8'h78;
  localparam logic [7:0] CharUpperX     = 8'h58;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharNine       = 8'h39;
  localparam logic [7:0] CharLowerA     = 8'h61;
  localparam logic [7:0] CharLowerF     = 8'h66;
  localparam logic [7:0] CharUpperA     = 8'h41;
  localparam logic [7:0] CharUpperF     = 8'h46;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StTooLarge    = 2'd1,
    StNegRejected = 2'd2
  } status_e;

  // register index is the 8-byte slot of paddr
  typedef enum logic {
    RegMaxUnsigned = 1'b0,
    RegNegLimit    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] c, input logic hex);
    digit_t d;
    logic [7:0] off;
    d   = '0;
    off = '0;
    if (c >= CharZero && c <= CharNine) begin
      off = c - CharZero;
      d.ok  = 1'b1;
      d.val = off[3:0];
    end else if (hex && c >= CharLowerA && c <= CharLowerF) begin
      off = c - CharLowerA + 8'd10;
      d.ok  = 1'b1;
      d.val = off[3:0];
    end else if (hex && c >= CharUpperA && c <= CharUpperF) begin
      off = c - CharUpperA + 8'd10;
      d.ok  = 1'b1;
      d.val = off[3:0];
    end
    return d;
  endfunction

endpackage

// ===== hdl/integer_literal_parser.sv =====
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses a decimal or hex integer token, one character per word, with
// optional sign, 0x prefix, underscores and saturation against a limit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | char_code, token_first/last,
//          |           |                           | radix_hex
//  out     | output    | out_valid_o / out_stall_i | value, status
//  cfg     | input     | APB psel/penable/pready   | max_unsigned, neg_limit
//
//  One word per cycle sustained while no token_last word waits on a stalled out.
//  A word is held in the input register, then one character step (x10/x16
//  multiply-add and limit compare) updates the token state and, on token_last,
//  loads the result register. Words without a result keep
//  flowing while out is stalled; a token_last word waits in the input register.
//  Reset clears all token state and loads the register reset values.
// ----------------------------------------------------------------------------
module integer_literal_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // character words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  char_code_i,
  input  logic                        token_first_i,
  input  logic                        token_last_i,
  input  logic                        radix_hex_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ilp_pkg::ValueW-1:0]  value_o,
  output logic [1:0]                  status_o,
  // config
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ilp_pkg::AddrW-1:0]   paddr,
  input  logic [ilp_pkg::ValueW-1:0]  pwdata,
  output logic [ilp_pkg::ValueW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned W  = ilp_pkg::ValueW;
  localparam int unsigned PW = ilp_pkg::ValueW + 4;

  // config registers
  logic [W-1:0] max_unsigned_q;
  logic [W-1:0] neg_limit_q;
  logic         cfg_wr;
  ilp_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ilp_pkg::reg_idx_e'(paddr[3]);

  always_comb begin
    case (cfg_idx)
      ilp_pkg::RegMaxUnsigned: prdata = max_unsigned_q;
      ilp_pkg::RegNegLimit:    prdata = neg_limit_q;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_unsigned_q <= '1;
      neg_limit_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ilp_pkg::RegMaxUnsigned: max_unsigned_q <= pwdata;
        ilp_pkg::RegNegLimit:    neg_limit_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] chr_q;
  logic       first_q, last_q, radix_q;
  logic       in_acc, fire;
  logic       out_vld_q, out_vld_d;

  assign fire       = in_vld_q && (!last_q || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chr_q   <= char_code_i;
      first_q <= token_first_i;
      last_q  <= token_last_i;
      radix_q <= radix_hex_i;
    end
  end

  // token state
  logic [W-1:0] mag_q, mag_d;
  logic neg_q, neg_d, ovf_q, ovf_d, ended_q, ended_d, sgn_q, sgn_d, hex_q, hex_d;

  logic [W-1:0]    mag_c, lim, mag_n;
  logic            neg_c, ovf_c, ended_c, sgn_c, hex_c;
  logic            neg_n, ovf_n, ended_n;
  ilp_pkg::digit_t dig;
  logic [PW-1:0]   prod;
  logic            is_sign, is_x;

  logic [W-1:0]     val_d;
  ilp_pkg::status_e st_d;

  always_comb begin
    mag_c   = first_q ? '0 : mag_q;
    neg_c   = first_q ? 1'b0 : neg_q;
    ovf_c   = first_q ? 1'b0 : ovf_q;
    ended_c = first_q ? 1'b0 : ended_q;
    sgn_c   = first_q ? 1'b1 : sgn_q;
    hex_c   = first_q ? radix_q : hex_q;

    dig  = ilp_pkg::digit_of(chr_q, hex_c);
    lim  = neg_c ? neg_limit_q : max_unsigned_q;
    prod = hex_c ? {mag_c, 4'b0000}
                 : ({1'b0, mag_c, 3'b000} + {3'b000, mag_c, 1'b0});
    prod = prod + {{(PW-4){1'b0}}, dig.val};

    is_sign = sgn_c && (chr_q == ilp_pkg::CharMinus || chr_q == ilp_pkg::CharPlus);
    is_x    = hex_c && (chr_q == ilp_pkg::CharLowerX || chr_q == ilp_pkg::CharUpperX)
              && (mag_c == '0);

    mag_n   = mag_c;
    neg_n   = neg_c;
    ovf_n   = ovf_c;
    ended_n = ended_c;
    if (!ovf_c && !ended_c) begin
      if (is_sign) begin
        neg_n = neg_c || (chr_q == ilp_pkg::CharMinus);
      end else if (chr_q == ilp_pkg::CharUnderscore || is_x) begin
        mag_n = mag_c;
      end else if (!dig.ok) begin
        ended_n = 1'b1;
      end else if (prod > {4'b0000, lim}) begin
        mag_n = lim;
        ovf_n = 1'b1;
      end else begin
        mag_n = prod[W-1:0];
      end
    end

    if (neg_n && neg_limit_q == '0) begin
      val_d = '0;
      st_d  = ilp_pkg::StNegRejected;
    end else begin
      val_d = neg_n ? ('0 - mag_n) : mag_n;
      st_d  = ovf_n ? ilp_pkg::StTooLarge : ilp_pkg::StOk;
    end

    mag_d   = mag_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    ended_d = ended_q;
    sgn_d   = sgn_q;
    hex_d   = hex_q;
    if (fire) begin
      hex_d = hex_c;
      if (last_q) begin
        mag_d   = '0;
        neg_d   = 1'b0;
        ovf_d   = 1'b0;
        ended_d = 1'b0;
        sgn_d   = 1'b1;
      end else begin
        mag_d   = mag_n;
        neg_d   = neg_n;
        ovf_d   = ovf_n;
        ended_d = ended_n;
        sgn_d   = 1'b0;
      end
    end
  end

  // result register
  logic [W-1:0]     value_q;
  ilp_pkg::status_e status_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire && last_q) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last_q) begin
      value_q  <= val_d;
      status_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      ovf_q     <= 1'b0;
      ended_q   <= 1'b0;
      sgn_q     <= 1'b1;
      hex_q     <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      mag_q     <= mag_d;
      neg_q     <= neg_d;
      ovf_q     <= ovf_d;
      ended_q   <= ended_d;
      sgn_q     <= sgn_d;
      hex_q     <= hex_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ===== hdl/ilp_checker.sv =====
// ----------------------------------------------------------------------------
// ilp_checker
// Port-level checks for the integer literal parser.
// ----------------------------------------------------------------------------
module ilp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [ilp_pkg::ValueW-1:0] value_o,
  input logic [1:0]                 status_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("result word changed while stalled");

  // with no result pending, input side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ilp_pkg::StOk || status_o == ilp_pkg::StTooLarge ||
                     status_o == ilp_pkg::StNegRejected))
    else $error("unknown status code");

  a_rejected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ilp_pkg::StNegRejected |-> value_o == '0)
    else $error("rejected negative with nonzero value");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .status_o    (status_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_literal_parser. Streams decimal and hex
// tokens (signs, 0x prefixes, underscores, stray characters, limit
// boundaries, broken flag sequences) under several limit settings, with
// random idle and stall bursts and one long output hold. Every result word
// is compared against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [63:0] AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMax   = 64'h8000_0000_0000_0000;
  localparam int          DrainCyc = 6;
  localparam int          HoldCyc  = 300;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } parse_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_stall;
  logic [7:0]                  char_code;
  logic                        token_first;
  logic                        token_last;
  logic                        radix_hex;
  logic                        out_valid;
  logic                        out_stall;
  logic [ilp_pkg::ValueW-1:0]  value;
  logic [1:0]                  status;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ilp_pkg::AddrW-1:0]   paddr;
  logic [ilp_pkg::ValueW-1:0]  pwdata;
  logic [ilp_pkg::ValueW-1:0]  prdata;
  logic                        pready;

  // parser model state
  logic [63:0] model_max;
  logic [63:0] model_neg;
  logic [63:0] tok_mag;
  bit          tok_neg;
  bit          tok_ovf;
  bit          tok_done;
  bit          tok_sign_ok;
  bit          tok_hex;

  parse_result_t pending_results[$];
  logic [7:0]    token_chars[$];

  int mismatches  = 0;
  int items_sent  = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int burst_left  = 0;

  integer_literal_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_code_i  (char_code),
    .token_first_i(token_first),
    .token_last_i (token_last),
    .radix_hex_i  (radix_hex),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_o      (value),
    .status_o     (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40) begin
      $display("mismatch %s: got %h want %h", what, got, want);
    end
    mismatches++;
  endtask

  function automatic int digit_value(input logic [7:0] c, input bit hex);
    if (c >= ilp_pkg::CharZero && c <= ilp_pkg::CharNine) begin
      return int'(c - ilp_pkg::CharZero);
    end
    if (hex && c >= ilp_pkg::CharLowerA && c <= ilp_pkg::CharLowerF) begin
      return int'(c - ilp_pkg::CharLowerA) + 10;
    end
    if (hex && c >= ilp_pkg::CharUpperA && c <= ilp_pkg::CharUpperF) begin
      return int'(c - ilp_pkg::CharUpperA) + 10;
    end
    return -1;
  endfunction

  task automatic clear_token();
    tok_mag     = '0;
    tok_neg     = 1'b0;
    tok_ovf     = 1'b0;
    tok_done    = 1'b0;
    tok_sign_ok = 1'b1;
  endtask

  task automatic parse_char(input logic [7:0] c, input bit first, input bit last,
                            input bit hex);
    bit            lead;
    int            d;
    logic [63:0]   base;
    logic [63:0]   lim;
    logic [63:0]   dig;
    parse_result_t r;
    if (first) begin
      clear_token();
      tok_hex = hex;
    end
    lead        = tok_sign_ok;
    tok_sign_ok = 1'b0;
    if (!tok_ovf && !tok_done) begin
      if (lead && (c == ilp_pkg::CharMinus || c == ilp_pkg::CharPlus)) begin
        if (c == ilp_pkg::CharMinus) tok_neg = 1'b1;
      end else if (c == ilp_pkg::CharUnderscore) begin
      end else if (tok_hex && (c == ilp_pkg::CharLowerX || c == ilp_pkg::CharUpperX)
                   && tok_mag == 0) begin
      end else begin
        d = digit_value(c, tok_hex);
        if (d < 0) begin
          tok_done = 1'b1;
        end else begin
          base = tok_hex ? 64'd16 : 64'd10;
          lim  = tok_neg ? model_neg : model_max;
          dig  = 64'(d);
          if (dig > lim || tok_mag > (lim - dig) / base) begin
            tok_mag = lim;
            tok_ovf = 1'b1;
          end else begin
            tok_mag = tok_mag * base + dig;
          end
        end
      end
    end
    if (last) begin
      if (tok_neg && model_neg == 0) begin
        r.value  = '0;
        r.status = ilp_pkg::StNegRejected;
      end else begin
        r.value  = tok_neg ? (64'd0 - tok_mag) : tok_mag;
        r.status = tok_ovf ? ilp_pkg::StTooLarge : ilp_pkg::StOk;
      end
      pending_results.push_back(r);
      clear_token();
    end
  endtask

  // output stall: random bursts, plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HoldCyc;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
      burst_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word without token", value, '0);
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (status !== want.status) begin
          report_mismatch("status", 64'(status), 64'(want.status));
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] c, input bit first, input bit last,
                           input bit hex);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    char_code   <= c;
    token_first <= first;
    token_last  <= last;
    radix_hex   <= hex;
    do @(posedge clk_i); while (in_stall);
    parse_char(c, first, last, hex);
    items_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
  endtask

  // radix_hex is random on words after the first; only the first samples it
  task automatic send_chars(input bit hex, input bit with_first);
    int n;
    n = token_chars.size();
    for (int i = 0; i < n; i++) begin
      send_word(token_chars[i], with_first && i == 0, i == n - 1,
                (i == 0) ? hex : bit'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_text(input string s, input bit hex, input bit with_first = 1'b1);
    token_chars.delete();
    push_text(s);
    send_chars(hex, with_first);
  endtask

  task automatic send_random_token(input bit hex, input bit with_first);
    int          r;
    int          n;
    bit          neg;
    logic [63:0] lim;
    logic [63:0] v;
    string       text;
    string       hex_digits;
    string       dec_digits;
    string       strays;
    hex_digits = "0123456789abcdefABCDEF";
    dec_digits = "0123456789";
    strays     = "+-xXg. ";
    token_chars.delete();
    r   = $urandom_range(0, 9);
    neg = (r < 3);
    if (r < 3) push_text("-");
    else if (r == 3) push_text("+");
    if (hex && $urandom_range(0, 3) != 0) push_text($urandom_range(0, 1) ? "0x" : "0X");
    if ($urandom_range(0, 3) == 0) begin
      // around the active limit
      lim  = neg ? model_neg : model_max;
      v    = lim + 64'($urandom_range(0, 4)) - 64'd2;
      text = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
      if ($urandom_range(0, 1)) text = text.toupper();
      push_text(text);
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 22) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) push_text("_");
        if (hex || $urandom_range(0, 29) == 0) begin
          token_chars.push_back(hex_digits[$urandom_range(0, 21)]);
        end else begin
          token_chars.push_back(dec_digits[$urandom_range(0, 9)]);
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) token_chars.push_back(8'($urandom_range(0, 255)));
      else token_chars.push_back(strays[$urandom_range(0, 6)]);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) token_chars.push_back(dec_digits[$urandom_range(0, 9)]);
    end
    send_chars(hex, with_first);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      send_word(8'($urandom_range(0, 255)), bit'($urandom_range(0, 1)),
                $urandom_range(0, 2) == 0, bit'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    int r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_noise();
      else send_random_token(bit'($urandom_range(0, 1)), r != 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic set_register(input ilp_pkg::reg_idx_e idx, input logic [63:0] data);
    logic [63:0] got;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == ilp_pkg::RegMaxUnsigned) model_max = data;
    else model_neg = data;
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== data) report_mismatch("register readback", got, data);
  endtask

  task automatic set_limits(input logic [63:0] max_val, input logic [63:0] neg_val);
    settle();
    set_register(ilp_pkg::RegMaxUnsigned, max_val);
    set_register(ilp_pkg::RegNegLimit, neg_val);
  endtask

  task automatic test_reset_config_directed();
    send_text("5", 1'b0);
    send_text("-7", 1'b0);
    send_text("+9", 1'b0);
    send_text("1_2z3", 1'b0);
    send_text("4-1", 1'b0);
    send_text("_", 1'b0);
    send_text("0xFf", 1'b1);
    send_text("x1", 1'b1);
    send_text("1x2", 1'b1);
    // no first flag: keeps hex from the previous token
    send_text("c", 1'b0, 1'b0);
  endtask

  task automatic test_limit_extremes();
    set_limits('0, '0);
    send_text("0", 1'b0);
    send_text("5", 1'b0);
    send_text("-3", 1'b0);
    set_limits(AllOnes, NegMax);
    send_text("-9223372036854775808", 1'b0);
    send_text("-9223372036854775809", 1'b0);
    send_text("18446744073709551615", 1'b0);
    send_text("1844674407370955161699", 1'b0);
    send_text("0xffffffffffffffff", 1'b1);
    send_text("0x10000000000000000", 1'b1);
    send_text("-0x8000000000000001", 1'b1);
    set_limits(64'd1, 64'd1);
    send_text("1", 1'b0);
    send_text("-2", 1'b0);
    send_text("0_1", 1'b0);
    run_random(100);
    // digit at or above the limit itself
    set_limits(64'd9, 64'd15);
    send_text("0xa", 1'b1);
    send_text("-0xf", 1'b1);
    run_random(80);
  endtask

  task automatic test_random_configs();
    logic [63:0] max_val;
    logic [63:0] neg_val;
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 2))
        0: begin
          max_val = {$urandom, $urandom};
          neg_val = {$urandom, $urandom};
        end
        1: begin
          max_val = 64'($urandom_range(0, 1000));
          neg_val = 64'($urandom_range(0, 1000));
        end
        default: begin
          max_val = $urandom_range(0, 1) ? AllOnes : 64'($urandom_range(0, 1));
          neg_val = $urandom_range(0, 1) ? NegMax : 64'($urandom_range(0, 1));
        end
      endcase
      if (neg_val > NegMax) neg_val = neg_val >> 1;
      set_limits(max_val, neg_val);
      run_random(90);
    end
  endtask

  task automatic test_output_backpressure();
    set_limits(AllOnes, NegMax);
    hold_reqs <= hold_reqs + 1;
    run_random(120);
  endtask

  task automatic test_steady_stream();
    set_limits(64'd999_999, 64'd1_000_000);
    sender_idle = 1'b0;
    receiver_idle <= 1'b0;
    run_random(200);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    char_code   = '0;
    token_first = 1'b0;
    token_last  = 1'b0;
    radix_hex   = 1'b0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    model_max   = AllOnes;
    model_neg   = '0;
    tok_hex     = 1'b0;
    clear_token();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config_directed();
    test_limit_extremes();
    test_random_configs();
    test_output_backpressure();
    test_steady_stream();
    settle();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
